FILE: rtl/gbi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gbi_pkg;

  localparam int COORD_W = 17;
  localparam int DEPTH_W = 16;
  localparam int FRAC_W = 16;
  localparam int WIDX_W = 6;
  localparam int DEF_GRID_ROWS = 64;
  localparam int DEF_GRID_COLS = 64;

  localparam logic [COORD_W-1:0] ONE_Q16 = COORD_W'(1) << FRAC_W;

  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef struct packed {
    logic en_row;
    logic en_prod;
    logic en_out;
  } blend_en_t;

endpackage

`default_nettype wire

FILE: rtl/gbi_locate.sv
`timescale 1ns / 1ps
`default_nettype none

module gbi_locate #(
  parameter int SIZE = gbi_pkg::DEF_GRID_COLS
) (
  input  wire logic [gbi_pkg::COORD_W+$clog2(SIZE)-1:0] scaled,
  output logic      [$clog2(SIZE)-1:0]                  idx,
  output gbi_pkg::coord_t                               off
);

  localparam int IW = $clog2(SIZE);
  localparam int SW = gbi_pkg::COORD_W + IW;
  localparam logic [IW:0] LIMIT = (IW + 1)'(SIZE - 2);

  logic [IW:0] idx_raw;
  logic        clamped;

  assign idx_raw = scaled[SW-1:gbi_pkg::FRAC_W];
  assign clamped = idx_raw > LIMIT;

  // once the index is clamped the offset is exactly one
  assign idx = clamped ? IW'(SIZE - 2) : idx_raw[IW-1:0];
  assign off = clamped ? gbi_pkg::ONE_Q16 : {1'b0, scaled[gbi_pkg::FRAC_W-1:0]};

endmodule

`default_nettype wire

FILE: rtl/gbi_bank_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module gbi_bank_mem #(
  parameter int AW = 10
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire gbi_pkg::depth_t wr_data,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output gbi_pkg::depth_t      rd_data
);

  gbi_pkg::depth_t mem_r [2**AW];
  gbi_pkg::depth_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: rtl/gbi_blend.sv
`timescale 1ns / 1ps
`default_nettype none

module gbi_blend (
  input  wire logic               clk,
  input  wire gbi_pkg::blend_en_t en,
  input  wire gbi_pkg::depth_t    v00,
  input  wire gbi_pkg::depth_t    v01,
  input  wire gbi_pkg::depth_t    v10,
  input  wire gbi_pkg::depth_t    v11,
  input  wire gbi_pkg::coord_t    dx,
  input  wire gbi_pkg::coord_t    dy,
  output gbi_pkg::depth_t         depth
);

  localparam int CW = gbi_pkg::COORD_W;
  localparam int RW = gbi_pkg::DEPTH_W + gbi_pkg::FRAC_W;
  localparam int PW = RW + CW;
  localparam logic [PW-1:0] HALF = PW'(1) << (2 * gbi_pkg::FRAC_W - 1);
  localparam gbi_pkg::depth_t SAT = '1;

  gbi_pkg::coord_t ex;
  logic [RW:0]     rowa_sum;
  logic [RW:0]     rowb_sum;
  logic [RW-1:0]   rowa_r;
  logic [RW-1:0]   rowb_r;
  gbi_pkg::coord_t ey_r;
  gbi_pkg::coord_t dy_r;
  logic [PW-1:0]   pa_r;
  logic [PW-1:0]   pb_r;
  logic [PW-1:0]   acc;
  logic [PW-2*gbi_pkg::FRAC_W-1:0] res;
  gbi_pkg::depth_t depth_r;

  assign ex = gbi_pkg::ONE_Q16 - dx;

  // blend along x first; the two weights sum to one so a row fits in 32 bits
  assign rowa_sum = (RW + 1)'(v00) * (RW + 1)'(ex) + (RW + 1)'(v01) * (RW + 1)'(dx);
  assign rowb_sum = (RW + 1)'(v10) * (RW + 1)'(ex) + (RW + 1)'(v11) * (RW + 1)'(dx);

  always_ff @(posedge clk) begin
    if (en.en_row) begin
      rowa_r <= rowa_sum[RW-1:0];
      rowb_r <= rowb_sum[RW-1:0];
      ey_r   <= gbi_pkg::ONE_Q16 - dy;
      dy_r   <= dy;
    end
  end

  always_ff @(posedge clk) begin
    if (en.en_prod) begin
      pa_r <= PW'(rowa_r) * PW'(ey_r);
      pb_r <= PW'(rowb_r) * PW'(dy_r);
    end
  end

  assign acc = pa_r + pb_r + HALF;
  assign res = acc[PW-1:2*gbi_pkg::FRAC_W];

  always_ff @(posedge clk) begin
    if (en.en_out) begin
      depth_r <= (res > (PW - 2 * gbi_pkg::FRAC_W)'(SAT)) ? SAT : res[gbi_pkg::DEPTH_W-1:0];
    end
  end

  assign depth = depth_r;

endmodule

`default_nettype wire

FILE: rtl/grid_bilinear_interpolator.sv
// grid bilinear interpolator
// holds a GRID_ROWS x GRID_COLS grid of Q0.16 depths and blends four corners per query
// input channel: in_valid / in_stall with in_cmd and the load and query fields
//   in_cmd load writes one grid entry and gives no result; loads outside the grid are dropped
//   in_cmd query takes Q1.16 x and y and gives one out_depth transfer
// output channel: out_valid / out_stall with out_depth, results in query order
// throughput: one item per cycle while out_stall is low; the grid sits in four banks split
//   by row and column parity, so the four corners of a cell are read in the same cycle
// a query passes through these registered stages in order:
//   input reg, scale multiply, bank read, row blend, column products, round and saturate
// a load lands in the grid in the bank read stage, in order with queries around it
// out_stall holds the result and stalls each stage behind it only once that stage is full;
//   in_stall rises when the input stage cannot move
// reset clears every valid bit; grid entries are undefined until loaded
`timescale 1ns / 1ps
`default_nettype none

module grid_bilinear_interpolator #(
  parameter int GRID_ROWS = gbi_pkg::DEF_GRID_ROWS,
  parameter int GRID_COLS = gbi_pkg::DEF_GRID_COLS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_cmd,
  input  wire logic [gbi_pkg::COORD_W-1:0]  in_x_coord,
  input  wire logic [gbi_pkg::COORD_W-1:0]  in_y_coord,
  input  wire logic [gbi_pkg::WIDX_W-1:0]   in_write_row,
  input  wire logic [gbi_pkg::WIDX_W-1:0]   in_write_col,
  input  wire logic [gbi_pkg::DEPTH_W-1:0]  in_write_depth,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [gbi_pkg::DEPTH_W-1:0]       out_depth
);

  localparam int RW  = $clog2(GRID_ROWS);
  localparam int CW  = $clog2(GRID_COLS);
  localparam int HRW = (RW > 1) ? RW - 1 : 1;
  localparam int HCW = (CW > 1) ? CW - 1 : 1;
  localparam int AW  = HRW + HCW;
  localparam int SXW = gbi_pkg::COORD_W + CW;
  localparam int SYW = gbi_pkg::COORD_W + RW;
  localparam logic [SXW-1:0] COLS_M1 = SXW'(GRID_COLS - 1);
  localparam logic [SYW-1:0] ROWS_M1 = SYW'(GRID_ROWS - 1);

  function automatic gbi_pkg::depth_t pick4(input gbi_pkg::depth_t q0, input gbi_pkg::depth_t q1,
                                            input gbi_pkg::depth_t q2, input gbi_pkg::depth_t q3,
                                            input logic [1:0] sel);
    gbi_pkg::depth_t v;
    case (sel)
      2'd0:    v = q0;
      2'd1:    v = q1;
      2'd2:    v = q2;
      default: v = q3;
    endcase
    return v;
  endfunction

  // stage valids and flow control
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt, v5_nxt, v6_nxt;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  logic en1, en2, en3, wr_go;
  gbi_pkg::blend_en_t blend_en;

  // stage 1: input
  gbi_pkg::cmd_t                 s1_cmd_r;
  gbi_pkg::coord_t               s1_x_r;
  gbi_pkg::coord_t               s1_y_r;
  logic [gbi_pkg::WIDX_W-1:0]    s1_wrow_r;
  logic [gbi_pkg::WIDX_W-1:0]    s1_wcol_r;
  gbi_pkg::depth_t               s1_wdepth_r;

  // stage 2: scaled coordinates
  gbi_pkg::cmd_t                 s2_cmd_r;
  logic [SXW-1:0]                s2_sx_r;
  logic [SYW-1:0]                s2_sy_r;
  logic [gbi_pkg::WIDX_W-1:0]    s2_wrow_r;
  logic [gbi_pkg::WIDX_W-1:0]    s2_wcol_r;
  gbi_pkg::depth_t               s2_wdepth_r;

  // stage 3: bank read
  gbi_pkg::coord_t               s3_dx_r;
  gbi_pkg::coord_t               s3_dy_r;
  logic [1:0]                    s3_par_r;

  logic [CW-1:0]   mx;
  logic [RW-1:0]   my;
  gbi_pkg::coord_t dx;
  gbi_pkg::coord_t dy;
  logic [HCW-1:0]  mx_half;
  logic [HRW-1:0]  my_half;
  logic            s2_is_load;
  logic            s2_in_grid;
  logic [RW-1:0]   wr_row;
  logic [CW-1:0]   wr_col;
  logic [AW-1:0]   wr_addr;
  gbi_pkg::depth_t bank_q [4];

  assign rdy6 = !v6_r || !out_stall;
  assign rdy5 = !v5_r || rdy6;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign s2_is_load = (s2_cmd_r == gbi_pkg::CMD_LOAD);
  assign s2_in_grid = (32'(s2_wrow_r) < GRID_ROWS) && (32'(s2_wcol_r) < GRID_COLS);

  assign en1   = rdy1 && in_valid;
  assign en2   = rdy2 && v1_r;
  assign en3   = rdy3 && v2_r && !s2_is_load;
  assign wr_go = rdy3 && v2_r && s2_is_load && s2_in_grid;
  assign blend_en.en_row  = rdy4 && v3_r;
  assign blend_en.en_prod = rdy5 && v4_r;
  assign blend_en.en_out  = rdy6 && v5_r;

  assign v1_nxt = rdy1 ? in_valid : v1_r;
  assign v2_nxt = rdy2 ? v1_r : v2_r;
  assign v3_nxt = rdy3 ? (v2_r && !s2_is_load) : v3_r;
  assign v4_nxt = rdy4 ? v3_r : v4_r;
  assign v5_nxt = rdy5 ? v4_r : v5_r;
  assign v6_nxt = rdy6 ? v5_r : v6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
      v5_r <= v5_nxt;
      v6_r <= v6_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_cmd_r    <= gbi_pkg::cmd_t'(in_cmd);
      s1_x_r      <= in_x_coord;
      s1_y_r      <= in_y_coord;
      s1_wrow_r   <= in_write_row;
      s1_wcol_r   <= in_write_col;
      s1_wdepth_r <= in_write_depth;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_cmd_r    <= s1_cmd_r;
      s2_sx_r     <= SXW'(s1_x_r) * COLS_M1;
      s2_sy_r     <= SYW'(s1_y_r) * ROWS_M1;
      s2_wrow_r   <= s1_wrow_r;
      s2_wcol_r   <= s1_wcol_r;
      s2_wdepth_r <= s1_wdepth_r;
    end
  end

  gbi_locate #(.SIZE(GRID_COLS)) u_locate_x (
    .scaled (s2_sx_r),
    .idx    (mx),
    .off    (dx)
  );

  gbi_locate #(.SIZE(GRID_ROWS)) u_locate_y (
    .scaled (s2_sy_r),
    .idx    (my),
    .off    (dy)
  );

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_dx_r  <= dx;
      s3_dy_r  <= dy;
      s3_par_r <= {my[0], mx[0]};
    end
  end

  assign mx_half = HCW'(mx >> 1);
  assign my_half = HRW'(my >> 1);
  assign wr_row  = RW'(s2_wrow_r);
  assign wr_col  = CW'(s2_wcol_r);
  assign wr_addr = {HRW'(wr_row >> 1), HCW'(wr_col >> 1)};

  // bank index is {row parity, column parity}
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic PR = 1'(b >> 1);
    localparam logic PC = 1'(b);

    logic [HRW-1:0] rd_row;
    logic [HCW-1:0] rd_col;
    logic           bank_we;

    // an odd cell index reaches the even bank at the next row or column
    assign rd_row  = PR ? my_half : my_half + HRW'(my[0]);
    assign rd_col  = PC ? mx_half : mx_half + HCW'(mx[0]);
    assign bank_we = wr_go && (wr_row[0] == PR) && (wr_col[0] == PC);

    gbi_bank_mem #(.AW(AW)) u_bank (
      .clk     (clk),
      .wr_en   (bank_we),
      .wr_addr (wr_addr),
      .wr_data (s2_wdepth_r),
      .rd_en   (en3),
      .rd_addr ({rd_row, rd_col}),
      .rd_data (bank_q[b])
    );
  end

  gbi_blend u_blend (
    .clk   (clk),
    .en    (blend_en),
    .v00   (pick4(bank_q[0], bank_q[1], bank_q[2], bank_q[3], s3_par_r)),
    .v01   (pick4(bank_q[0], bank_q[1], bank_q[2], bank_q[3], s3_par_r ^ 2'b01)),
    .v10   (pick4(bank_q[0], bank_q[1], bank_q[2], bank_q[3], s3_par_r ^ 2'b10)),
    .v11   (pick4(bank_q[0], bank_q[1], bank_q[2], bank_q[3], s3_par_r ^ 2'b11)),
    .dx    (s3_dx_r),
    .dy    (s3_dy_r),
    .depth (out_depth)
  );

  assign in_stall  = !rdy1;
  assign out_valid = v6_r;

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import gbi_pkg::*;

  localparam int ROWS = DEF_GRID_ROWS;
  localparam int COLS = DEF_GRID_COLS;
  localparam int TARGET_ITEMS = 1100;
  localparam int HOLD_AT = 150;
  localparam int HOLD_CYCLES = 40;
  localparam int PAUSE_AT = 520;
  localparam int DRAIN_CYCLES = 20;
  localparam int STALL_LIMIT = 1000;

  typedef struct {
    cmd_t               cmd;
    coord_t             x;
    coord_t             y;
    logic [WIDX_W-1:0]  row;
    logic [WIDX_W-1:0]  col;
    depth_t             val;
  } grid_op_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_cmd = 1'b0;
  coord_t in_x_coord = '0;
  coord_t in_y_coord = '0;
  logic [WIDX_W-1:0] in_write_row = '0;
  logic [WIDX_W-1:0] in_write_col = '0;
  depth_t in_write_depth = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  depth_t out_depth;

  // queues fill at the front and drain from the back
  grid_op_t pending_ops[$];
  depth_t expected_depths[$];
  depth_t model_grid[ROWS*COLS];
  bit gen_written[ROWS*COLS];

  grid_op_t cur_op;
  depth_t want;
  bit took_in = 0;
  bit go;
  bit stall_now;
  bit hold_done = 0;
  bit pause_done = 0;
  int hold_left = 0;
  int total_items = 0;
  int items_sent = 0;
  int loads_sent = 0;
  int queries_sent = 0;
  int depths_checked = 0;
  int idle_phase = 0;
  int errors = 0;
  int idle_cycles = 0;

  grid_bilinear_interpolator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_x_coord     (in_x_coord),
    .in_y_coord     (in_y_coord),
    .in_write_row   (in_write_row),
    .in_write_col   (in_write_col),
    .in_write_depth (in_write_depth),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_depth      (out_depth)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // cell index and Q.16 offset of one coordinate
  function automatic void split_coord(input coord_t c, input int size, output int idx,
                                      output bit [63:0] off);
    bit [63:0] scaled;
    scaled = 64'(c) * 64'(size - 1);
    idx = int'(scaled >> FRAC_W);
    if (idx > size - 2) idx = size - 2;
    off = scaled - (64'(idx) << FRAC_W);
    if (off > 64'(ONE_Q16)) off = 64'(ONE_Q16);
  endfunction

  function automatic depth_t interp_depth(input coord_t x, input coord_t y);
    int cx;
    int cy;
    bit [63:0] dx;
    bit [63:0] dy;
    bit [63:0] ex;
    bit [63:0] ey;
    bit [63:0] acc;
    split_coord(x, COLS, cx, dx);
    split_coord(y, ROWS, cy, dy);
    ex = 64'(ONE_Q16) - dx;
    ey = 64'(ONE_Q16) - dy;
    acc = 64'(model_grid[cy*COLS + cx]) * (ex * ey)
        + 64'(model_grid[cy*COLS + cx + 1]) * (dx * ey)
        + 64'(model_grid[(cy + 1)*COLS + cx]) * (ex * dy)
        + 64'(model_grid[(cy + 1)*COLS + cx + 1]) * (dx * dy);
    acc = (acc + (64'd1 << 31)) >> 32;
    if (acc > 64'hFFFF) acc = 64'hFFFF;
    return depth_t'(acc);
  endfunction

  task automatic push_load(input int row, input int col, input depth_t val);
    grid_op_t op;
    op.cmd = CMD_LOAD;
    op.x = coord_t'($urandom_range(0, 131071));
    op.y = coord_t'($urandom_range(0, 131071));
    op.row = row[WIDX_W-1:0];
    op.col = col[WIDX_W-1:0];
    op.val = val;
    gen_written[row*COLS + col] = 1'b1;
    pending_ops.push_front(op);
  endtask

  // loads any corner not yet written, then the query itself
  task automatic queue_query(input coord_t x, input coord_t y);
    grid_op_t op;
    int cx;
    int cy;
    bit [63:0] ox;
    bit [63:0] oy;
    split_coord(x, COLS, cx, ox);
    split_coord(y, ROWS, cy, oy);
    for (int r = cy; r <= cy + 1; r++)
      for (int c = cx; c <= cx + 1; c++)
        if (!gen_written[r*COLS + c]) push_load(r, c, depth_t'($urandom));
    op.cmd = CMD_QUERY;
    op.x = x;
    op.y = y;
    op.row = WIDX_W'($urandom);
    op.col = WIDX_W'($urandom);
    op.val = depth_t'($urandom);
    pending_ops.push_front(op);
  endtask

  function automatic coord_t pick_coord(input int kind);
    int pick;
    if (kind < 50) return coord_t'($urandom_range(0, 8191));
    if (kind < 85) return coord_t'($urandom_range(0, 65536));
    if (kind < 92) begin
      pick = $urandom_range(0, 2);
      return (pick == 0) ? coord_t'(0) : (pick == 1) ? ONE_Q16 : coord_t'(32768);
    end
    return coord_t'($urandom_range(65537, 131071));
  endfunction

  initial begin
    int kind;
    push_load(0, 0, 16'h0000);
    push_load(0, 1, 16'hFFFF);
    push_load(1, 0, 16'hFFFF);
    push_load(1, 1, 16'h0000);
    queue_query(coord_t'(0), coord_t'(0));
    queue_query(coord_t'(1040), coord_t'(520));
    push_load(ROWS - 2, COLS - 2, 16'hFFFF);
    push_load(ROWS - 2, COLS - 1, 16'hFFFF);
    push_load(ROWS - 1, COLS - 2, 16'hFFFF);
    push_load(ROWS - 1, COLS - 1, 16'hFFFF);
    queue_query(ONE_Q16, ONE_Q16);
    queue_query(coord_t'(17'h1FFFF), coord_t'(17'h1FFFF));
    // exact half between 1 and 0 rounds up
    push_load(0, 31, 16'h0001);
    push_load(0, 32, 16'h0000);
    push_load(1, 31, 16'h0000);
    push_load(1, 32, 16'h0000);
    queue_query(coord_t'(32768), coord_t'(0));
    queue_query(coord_t'(0), ONE_Q16);
    queue_query(ONE_Q16, coord_t'(0));

    while (pending_ops.size() < TARGET_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        push_load($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1),
                  depth_t'($urandom));
      end else begin
        kind = $urandom_range(0, 99);
        queue_query(pick_coord(kind), pick_coord($urandom_range(0, 99)));
      end
    end
    total_items = pending_ops.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (items_sent < total_items) @(negedge clk);
    while (expected_depths.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_depths.size() != 0) begin
      errors += expected_depths.size();
      $display("%0d expected depths never arrived", expected_depths.size());
    end
    $display("covered %0d loads and %0d queries over four traffic mixes,", loads_sent,
             queries_sent);
    $display("one long output hold and one full drain; %0d depths checked, %0d mismatches",
             depths_checked, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // input side: predict on each accepted transfer
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      took_in = 1'b1;
      if (cur_op.cmd == CMD_LOAD) begin
        model_grid[int'(cur_op.row)*COLS + int'(cur_op.col)] = cur_op.val;
        loads_sent++;
      end else begin
        expected_depths.push_front(interp_depth(cur_op.x, cur_op.y));
        queries_sent++;
      end
      items_sent++;
      idle_phase = items_sent * 4 / total_items;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (took_in || !in_valid)) begin
      took_in = 1'b0;
      go = pending_ops.size() != 0;
      if (!pause_done && items_sent >= PAUSE_AT) begin
        if (expected_depths.size() != 0) go = 1'b0;
        else pause_done = 1'b1;
      end
      if ((idle_phase == 1 && $urandom_range(0, 99) < 68) ||
          (idle_phase == 3 && $urandom_range(0, 99) < 38))
        go = 1'b0;
      if (go) begin
        cur_op = pending_ops.pop_back();
        in_valid <= 1'b1;
        in_cmd <= cur_op.cmd;
        in_x_coord <= cur_op.x;
        in_y_coord <= cur_op.y;
        in_write_row <= cur_op.row;
        in_write_col <= cur_op.col;
        in_write_depth <= cur_op.val;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_now = 1'b1;
      end else if (idle_phase == 2) begin
        stall_now = $urandom_range(0, 99) < 68;
      end else if (idle_phase == 3) begin
        stall_now = $urandom_range(0, 99) < 38;
      end else begin
        stall_now = 1'b0;
      end
      out_stall <= stall_now;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_depths.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected depth transfer: got %0d", out_depth);
      end else begin
        want = expected_depths.pop_back();
        depths_checked++;
        if (out_depth !== want) begin
          errors++;
          if (errors <= 10)
            $display("depth mismatch on result %0d: expected %0d, got %0d", depths_checked,
                     want, out_depth);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no transfer for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule
